@@ rtl/core/rtcdit_pkg.sv @@
// Shared types and constants for the real-time counter alarm table.
// Used by rtcdit_cmp and rtc_deadline_interrupt_table; no dependencies.
`default_nettype none

package rtcdit_pkg;

   localparam int NUM_SLOTS    = 8;
   localparam int MAX_RESULTS  = 8;
   localparam int IDX_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ROUND_W      = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
   localparam int CNT_W        = 64;
   localparam int SLOT_W       = 3;
   localparam int LINE_W       = 8;
   localparam int VALUE_W      = 32;
   localparam int OFFSET_W     = 32;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 32'd300000;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_SET    = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_FIRE   = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic due;
      logic take;
   } cmp_res_type;

endpackage

`default_nettype wire

@@ rtl/core/rtc_deadline_interrupt_table.sv @@
// Real-time counter with NUM_SLOTS alarm slots, sequenced over one compare unit.
// Depends on rtcdit_pkg and rtcdit_cmp.
//
// Usage:
//   Requests enter on req_* (valid/stall); a request is taken when req_valid is
//   high and req_stall low. Results leave on rsp_* through one output register;
//   rsp_last marks the final result of a request.
//   Set: no result. Cancel and read: one result.
//   Tick: bumps the counter, then runs up to MAX_RESULTS rounds. Each round
//   walks the slots one per cycle through the compare unit, then loads the
//   earliest due alarm into the output register once it is free; a tick
//   with nothing due gives no result. The compare unit sets the scan rate.
//   A new request is taken as soon as the sequencer is idle, even while the
//   last result still waits in the output register.
//   When rsp_stall is high the output register holds and the sequencer waits
//   before loading the next result.
//   csr_wr_en writes deadline_offset at once; write it only while idle.
//   Reset clears the counter, all armed flags and restores deadline_offset.
`default_nettype none

module rtc_deadline_interrupt_table
   import rtcdit_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_func,
   input  wire logic [SLOT_W-1:0]   req_slot,
   input  wire logic [CNT_W-1:0]    req_deadline,
   input  wire logic [LINE_W-1:0]   req_irq_line,
   input  wire logic [VALUE_W-1:0]  req_irq_value,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [SLOT_W-1:0]        rsp_fired_slot,
   output logic [LINE_W-1:0]        rsp_fired_line,
   output logic [VALUE_W-1:0]       rsp_fired_value,
   output logic                     rsp_was_armed,
   output logic [CNT_W-1:0]         rsp_counter_now,
   output logic                     rsp_last,

   input  wire logic                csr_wr_en,
   input  wire logic [OFFSET_W-1:0] csr_wr_data
);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        counter_ff, counter_in;
   logic [NUM_SLOTS-1:0]    armed_ff, armed_in;
   logic [OFFSET_W-1:0]     offset_ff;

   logic [CNT_W-1:0]        dl_ff    [NUM_SLOTS];
   logic [LINE_W-1:0]       line_ff  [NUM_SLOTS];
   logic [VALUE_W-1:0]      value_ff [NUM_SLOTS];

   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [ROUND_W-1:0]      round_ff, round_in;
   logic                    have_ff, have_in;
   logic                    multi_ff, multi_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic [CNT_W-1:0]        best_dl_ff, best_dl_in;
   logic [LINE_W-1:0]       best_line_ff, best_line_in;
   logic [VALUE_W-1:0]      best_value_ff, best_value_in;

   kind_type                op_kind_ff, op_kind_in;
   logic [SLOT_W-1:0]       op_slot_ff, op_slot_in;
   logic                    op_was_ff, op_was_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                rsp_kind_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [LINE_W-1:0]       rsp_line_ff;
   logic [VALUE_W-1:0]      rsp_value_ff;
   logic                    rsp_was_ff;
   logic [CNT_W-1:0]        rsp_cnt_ff;
   logic                    rsp_last_ff;

   logic                    ld;
   kind_type                ld_kind;
   logic [SLOT_W-1:0]       ld_slot;
   logic [LINE_W-1:0]       ld_line;
   logic [VALUE_W-1:0]      ld_value;
   logic                    ld_was;
   logic                    ld_last;

   logic                    req_acc;
   logic                    out_free;
   logic                    slot_ok;
   logic [IDX_W-1:0]        req_idx;
   logic [CNT_W:0]          dl_sum;
   logic [CNT_W-1:0]        dl_sat;
   logic                    fire_last;
   cmp_res_type             cmp;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_ok   = (int'(req_slot) < NUM_SLOTS);
   assign req_idx   = req_slot[IDX_W-1:0];
   assign dl_sum    = {1'b0, req_deadline} + {{(CNT_W+1-OFFSET_W){1'b0}}, offset_ff};
   assign dl_sat    = dl_sum[CNT_W] ? {CNT_W{1'b1}} : dl_sum[CNT_W-1:0];
   assign fire_last = !multi_ff || (round_ff == ROUND_W'(MAX_RESULTS - 1));

   rtcdit_cmp u_cmp (
      .cand_armed    (armed_ff[idx_ff]),
      .cand_deadline (dl_ff[idx_ff]),
      .counter_now   (counter_ff),
      .have_best     (have_ff),
      .best_deadline (best_dl_ff),
      .res           (cmp)
   );

   always_comb begin
      state_in      = state_ff;
      counter_in    = counter_ff;
      armed_in      = armed_ff;
      idx_in        = idx_ff;
      round_in      = round_ff;
      have_in       = have_ff;
      multi_in      = multi_ff;
      best_in       = best_ff;
      best_dl_in    = best_dl_ff;
      best_line_in  = best_line_ff;
      best_value_in = best_value_ff;
      op_kind_in    = op_kind_ff;
      op_slot_in    = op_slot_ff;
      op_was_in     = op_was_ff;
      ld            = 1'b0;
      ld_kind       = op_kind_ff;
      ld_slot       = op_slot_ff;
      ld_line       = '0;
      ld_value      = '0;
      ld_was        = op_was_ff;
      ld_last       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (func_type'(req_func))
                  FUNC_TICK: begin
                     counter_in = counter_ff + 1'b1;
                     idx_in     = '0;
                     round_in   = '0;
                     have_in    = 1'b0;
                     multi_in   = 1'b0;
                     state_in   = ST_SCAN;
                  end
                  FUNC_SET: begin
                     if (slot_ok) begin
                        armed_in[req_idx] = 1'b1;
                     end
                  end
                  FUNC_CANCEL: begin
                     op_kind_in = KIND_CANCEL;
                     op_slot_in = req_slot;
                     op_was_in  = slot_ok && armed_ff[req_idx];
                     if (slot_ok) begin
                        armed_in[req_idx] = 1'b0;
                     end
                     state_in = ST_RESP;
                  end
                  FUNC_READ: begin
                     op_kind_in = KIND_READ;
                     op_slot_in = '0;
                     op_was_in  = 1'b0;
                     state_in   = ST_RESP;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (cmp.due && have_ff) begin
               multi_in = 1'b1;
            end
            if (cmp.take) begin
               have_in       = 1'b1;
               best_in       = idx_ff;
               best_dl_in    = dl_ff[idx_ff];
               best_line_in  = line_ff[idx_ff];
               best_value_in = value_ff[idx_ff];
            end
            if (idx_ff == IDX_W'(NUM_SLOTS - 1)) begin
               state_in = have_in ? ST_EMIT : ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ld                = 1'b1;
               ld_kind           = KIND_FIRE;
               ld_slot           = SLOT_W'(best_ff);
               ld_line           = best_line_ff;
               ld_value          = best_value_ff;
               ld_was            = 1'b0;
               ld_last           = fire_last;
               armed_in[best_ff] = 1'b0;
               if (fire_last) begin
                  state_in = ST_IDLE;
               end else begin
                  round_in = round_ff + 1'b1;
                  idx_in   = '0;
                  have_in  = 1'b0;
                  multi_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               ld       = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (ld) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         armed_ff     <= '0;
         offset_ff    <= OFFSET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      round_ff      <= round_in;
      have_ff       <= have_in;
      multi_ff      <= multi_in;
      best_ff       <= best_in;
      best_dl_ff    <= best_dl_in;
      best_line_ff  <= best_line_in;
      best_value_ff <= best_value_in;
      op_kind_ff    <= op_kind_in;
      op_slot_ff    <= op_slot_in;
      op_was_ff     <= op_was_in;
      if (req_acc && (func_type'(req_func) == FUNC_SET) && slot_ok) begin
         dl_ff[req_idx]    <= dl_sat;
         line_ff[req_idx]  <= req_irq_line;
         value_ff[req_idx] <= req_irq_value;
      end
      if (ld) begin
         rsp_kind_ff  <= ld_kind;
         rsp_slot_ff  <= ld_slot;
         rsp_line_ff  <= ld_line;
         rsp_value_ff <= ld_value;
         rsp_was_ff   <= ld_was;
         rsp_cnt_ff   <= counter_ff;
         rsp_last_ff  <= ld_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_fired_slot  = rsp_slot_ff;
   assign rsp_fired_line  = rsp_line_ff;
   assign rsp_fired_value = rsp_value_ff;
   assign rsp_was_armed   = rsp_was_ff;
   assign rsp_counter_now = rsp_cnt_ff;
   assign rsp_last        = rsp_last_ff;

   a_emit_armed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> armed_ff[best_ff])
      else $error("emitting slot is not armed");

   a_emit_due: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (best_dl_ff <= counter_ff))
      else $error("emitting slot deadline is beyond the counter");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (func_type'(req_func) == FUNC_TICK))
      |=> (counter_ff == $past(counter_ff) + 1'b1))
      else $error("tick did not advance the counter");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind_type'(rsp_kind) != KIND_FIRE)) |-> rsp_last)
      else $error("cancel or read answer without last");

endmodule

`default_nettype wire

@@ rtl/core/rtcdit_cmp.sv @@
// Shared deadline compare unit: checks one slot against the counter and the
// best candidate so far. Depends on rtcdit_pkg.
`default_nettype none

module rtcdit_cmp
   import rtcdit_pkg::*;
(
   input  wire logic             cand_armed,
   input  wire logic [CNT_W-1:0] cand_deadline,
   input  wire logic [CNT_W-1:0] counter_now,
   input  wire logic             have_best,
   input  wire logic [CNT_W-1:0] best_deadline,
   output cmp_res_type           res
);

   always_comb begin
      res.due  = cand_armed && (cand_deadline <= counter_now);
      res.take = res.due && (!have_best || (cand_deadline < best_deadline));
   end

endmodule

`default_nettype wire
